// ===== rtl/smms_pkg.sv =====
// shared widths, constants, state encoding and control structs for the statistics core
package smms_pkg;

  localparam int SAMPLE_W = 15;
  localparam int MINUTE_W = 11;
  localparam int COUNT_W  = 8;
  localparam int SUM_W    = 22;
  localparam int SUMSQ_W  = 35;
  localparam int SQ_W     = 28;
  localparam int DIV_W    = 43;
  localparam int DVS_W    = 16;
  localparam int VAR_W    = 28;
  localparam int STD_W    = 14;
  localparam int CNT_W    = 6;
  localparam int IN_W     = 32;
  localparam int OUT_W    = 96;

  localparam logic [COUNT_W-1:0] MAX_SAMPLES = 8'd128;
  localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd100;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_HI  = 15'sd9999;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_LO  = -15'sd9999;
  localparam logic signed [SAMPLE_W-1:0] HIGH_RESET = -15'sd10000;
  localparam logic signed [SAMPLE_W-1:0] LOW_RESET  = 15'sd10000;

  localparam logic [CNT_W-1:0] DIV_LAST  = 6'd42;
  localparam logic [CNT_W-1:0] SQRT_LAST = 6'd13;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV_MEAN,
    ST_MEAN,
    ST_DIV_VAR,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic div_step;
    logic mean_store;
    logic sqrt_load;
    logic sqrt_step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic set_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/smms_ctrl.sv =====
// controller: accepts samples and sequences the per-set divide and square root
module smms_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tlast,
  input  smms_pkg::dp_status_t status,
  output logic                s_tready,
  output smms_pkg::dp_cmd_t   cmd
);
  import smms_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic              take;

  assign take = (state == ST_IDLE) && s_tvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = '0;
    case (state)
      ST_IDLE: begin
        if (take && s_tlast && status.set_done) state_next = ST_MUL;
      end
      ST_MUL:  state_next = ST_DIV_MEAN;
      ST_DIV_MEAN: begin
        if (cnt == DIV_LAST) state_next = ST_MEAN;
        else cnt_next = cnt + 1'b1;
      end
      ST_MEAN: state_next = ST_DIV_VAR;
      ST_DIV_VAR: begin
        if (cnt == DIV_LAST) state_next = ST_VAR;
        else cnt_next = cnt + 1'b1;
      end
      ST_VAR:  state_next = ST_SQRT;
      ST_SQRT: begin
        if (cnt == SQRT_LAST) state_next = ST_DONE;
        else cnt_next = cnt + 1'b1;
      end
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.take = take;
      end
      ST_MUL:      cmd.mul        = 1'b1;
      ST_DIV_MEAN: cmd.div_step   = 1'b1;
      ST_MEAN:     cmd.mean_store = 1'b1;
      ST_DIV_VAR:  cmd.div_step   = 1'b1;
      ST_VAR:      cmd.sqrt_load  = 1'b1;
      ST_SQRT:     cmd.sqrt_step  = 1'b1;
      ST_DONE:     cmd.out_load   = status.out_free;
      default:     cmd            = '0;
    endcase
  end

endmodule

// ===== rtl/smms_dp.sv =====
// datapath: accumulators, set snapshot, shared divider, square root and output register
module smms_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  smms_pkg::dp_cmd_t             cmd,
  input  logic [smms_pkg::IN_W-1:0]     s_tdata,
  input  logic                          s_tlast,
  input  logic                          cfg_we,
  input  logic [smms_pkg::COUNT_W-1:0]  cfg_data,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [smms_pkg::OUT_W-1:0]    m_tdata,
  output logic [0:0]                    m_tuser,
  output smms_pkg::dp_status_t          status
);
  import smms_pkg::*;

  logic [COUNT_W-1:0] entry_limit;
  logic [COUNT_W-1:0] limit;

  // running accumulators
  logic signed [SUM_W-1:0]    sum, sum_next;
  logic [SUMSQ_W-1:0]         sumsq, sumsq_next;
  logic [COUNT_W-1:0]         count, count_next;
  logic signed [SAMPLE_W-1:0] high, high_next, low, low_next;
  logic [MINUTE_W-1:0]        high_min, high_min_next, low_min, low_min_next;
  logic                       flag, flag_next;

  logic signed [SAMPLE_W-1:0] s_raw, s_sat;
  logic [MINUTE_W-1:0]        minute;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                       take_ok;

  // snapshot of a finished set
  logic signed [SUM_W-1:0]    snap_sum;
  logic [SUMSQ_W-1:0]         snap_sumsq;
  logic [COUNT_W-1:0]         snap_n;
  logic signed [SAMPLE_W-1:0] snap_high, snap_low;
  logic [MINUTE_W-1:0]        snap_high_min, snap_low_min;
  logic                       snap_flag;

  logic [SUM_W-1:0]           abs_sum;
  logic [2*SUM_W-1:0]         ss_full;
  logic [DIV_W-1:0]           prod_nq, prod_ss;
  logic [DVS_W-1:0]           nn;
  logic [DIV_W:0]             diff;

  // shared restoring divider
  logic [DIV_W-1:0]           dq;
  logic [DVS_W-1:0]           rem, divisor;
  logic [DVS_W:0]             d_trial;
  logic                       d_ge;
  logic signed [SAMPLE_W-1:0] mean;

  // digit-by-digit square root
  logic [VAR_W-1:0]           sx;
  logic [DVS_W-1:0]           sr;
  logic [STD_W-1:0]           root;
  logic [DVS_W+1:0]           r_trial, r_sub;
  logic                       r_ge;

  always_ff @(posedge clk) begin
    if (rst) entry_limit <= LIMIT_RESET;
    else if (cfg_we) entry_limit <= cfg_data;
  end

  assign limit  = (entry_limit > MAX_SAMPLES) ? MAX_SAMPLES : entry_limit;
  assign s_raw  = s_tdata[SAMPLE_W-1:0];
  assign minute = s_tdata[SAMPLE_W+MINUTE_W-1:SAMPLE_W];

  always_comb begin
    if (s_raw > SAMPLE_HI)      s_sat = SAMPLE_HI;
    else if (s_raw < SAMPLE_LO) s_sat = SAMPLE_LO;
    else                        s_sat = s_raw;
  end

  assign sq_full = (2*SAMPLE_W)'(s_sat) * (2*SAMPLE_W)'(s_sat);
  assign take_ok = count < limit;

  always_comb begin
    sum_next      = sum;
    sumsq_next    = sumsq;
    count_next    = count;
    high_next     = high;
    high_min_next = high_min;
    low_next      = low;
    low_min_next  = low_min;
    flag_next     = flag | ~take_ok;
    if (take_ok) begin
      sum_next   = sum + SUM_W'(s_sat);
      sumsq_next = sumsq + SUMSQ_W'(sq_full[SQ_W-1:0]);
      count_next = count + 1'b1;
      if (s_sat > high) begin
        high_next     = s_sat;
        high_min_next = minute;
      end
      if (s_sat < low) begin
        low_next     = s_sat;
        low_min_next = minute;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum      <= '0;
      sumsq    <= '0;
      count    <= '0;
      high     <= HIGH_RESET;
      high_min <= '0;
      low      <= LOW_RESET;
      low_min  <= '0;
      flag     <= 1'b0;
    end else if (cmd.take) begin
      if (s_tlast) begin
        sum      <= '0;
        sumsq    <= '0;
        count    <= '0;
        high     <= HIGH_RESET;
        high_min <= '0;
        low      <= LOW_RESET;
        low_min  <= '0;
        flag     <= 1'b0;
      end else begin
        sum      <= sum_next;
        sumsq    <= sumsq_next;
        count    <= count_next;
        high     <= high_next;
        high_min <= high_min_next;
        low      <= low_next;
        low_min  <= low_min_next;
        flag     <= flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && s_tlast) begin
      snap_sum      <= sum_next;
      snap_sumsq    <= sumsq_next;
      snap_n        <= count_next;
      snap_high     <= high_next;
      snap_high_min <= high_min_next;
      snap_low      <= low_next;
      snap_low_min  <= low_min_next;
      snap_flag     <= flag_next;
    end
  end

  assign abs_sum = snap_sum[SUM_W-1] ? SUM_W'(-snap_sum) : SUM_W'(snap_sum);
  assign ss_full = (2*SUM_W)'(abs_sum) * (2*SUM_W)'(abs_sum);
  // n*sumsq never falls below sum^2, the clamp only guards the sign
  assign diff    = {1'b0, prod_nq} - {1'b0, prod_ss};

  assign d_trial = {rem, dq[DIV_W-1]};
  assign d_ge    = d_trial >= {1'b0, divisor};

  assign r_trial = {sr, sx[VAR_W-1:VAR_W-2]};
  assign r_sub   = {2'b00, root, 2'b01};
  assign r_ge    = r_trial >= r_sub;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_nq <= {{(DIV_W-COUNT_W){1'b0}}, snap_n} * {{(DIV_W-SUMSQ_W){1'b0}}, snap_sumsq};
      prod_ss <= ss_full[DIV_W-1:0];
      nn      <= DVS_W'(snap_n) * DVS_W'(snap_n);
      dq      <= DIV_W'(abs_sum);
      rem     <= '0;
      divisor <= DVS_W'(snap_n);
    end else if (cmd.mean_store) begin
      dq      <= diff[DIV_W] ? '0 : diff[DIV_W-1:0];
      rem     <= '0;
      divisor <= nn;
    end else if (cmd.div_step) begin
      rem <= d_ge ? DVS_W'(d_trial - {1'b0, divisor}) : d_trial[DVS_W-1:0];
      dq  <= {dq[DIV_W-2:0], d_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_store) begin
      mean <= snap_sum[SUM_W-1] ? -$signed(dq[SAMPLE_W-1:0]) : $signed(dq[SAMPLE_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_load) begin
      sx   <= dq[VAR_W-1:0];
      sr   <= '0;
      root <= '0;
    end else if (cmd.sqrt_step) begin
      sr   <= r_ge ? DVS_W'(r_trial - r_sub) : r_trial[DVS_W-1:0];
      root <= {root[STD_W-2:0], r_ge};
      sx   <= {sx[VAR_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {7'b0, snap_n, root, mean, snap_low_min, snap_low,
                  snap_high_min, snap_high};
      m_tuser <= snap_flag;
    end
  end

  assign status.set_done = count_next != '0;
  assign status.out_free = ~m_tvalid | m_tready;

endmodule

// ===== rtl/sample_min_max_mean_std_stats_core.sv =====
// Temperature statistics core: each accepted sample (one per cycle while idle) updates the
// running max/min with their minute of day, sum, sum of squares and count, up to
// min(entry_limit, 128) samples per set; later samples are dropped and set the truncated
// flag. The request marked tlast closes the set and, if any sample was accepted, produces
// one result with max, min, mean (truncated toward zero), population standard deviation
// (floor square root) and count. No sample is taken while a set closes: a multiply step,
// two passes of a shared 43-step bit-serial divider (mean, then variance) each followed
// by a store step, a 14-step square root and the load of the output register. A finished
// result sits in an output register, so the next set may start accumulating while it
// waits; the core stalls only if a new result is ready before the previous one was taken.
// A last request that found no accepted sample gives no result and the core stays idle.
module sample_min_max_mean_std_stats_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample[14:0], minute_of_day[25:15], zeros
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // max_value[14:0], max_minute[25:15], min_value[40:26],
                                 // min_minute[51:41], mean_value[66:52], std_dev[80:67],
                                 // sample_count[88:81], zeros
  output logic [0:0]  m_tuser,   // truncated[0]
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);
  import smms_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  smms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .status   (status),
    .s_tready (s_tready),
    .cmd      (cmd)
  );

  smms_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .status   (status)
  );

endmodule

// ===== tb/sv/tb.sv =====
// self-checking testbench for the running min/max/mean/std statistics core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smms_pkg::*;

  localparam int SETTLE_CYCLES = 90;
  localparam int SHOW_LIMIT    = 10;

  typedef struct {
    logic signed [SAMPLE_W-1:0] hi_value;
    logic [MINUTE_W-1:0]        hi_minute;
    logic signed [SAMPLE_W-1:0] lo_value;
    logic [MINUTE_W-1:0]        lo_minute;
    logic signed [SAMPLE_W-1:0] mean;
    logic [STD_W-1:0]           std_dev;
    logic [COUNT_W-1:0]         count;
    logic                       truncated;
  } stats_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_data = '0;

  // predictor copy of the register and the running set state
  logic [COUNT_W-1:0]         limit_reg;
  logic signed [SUM_W-1:0]    run_sum;
  logic [SUMSQ_W-1:0]         run_sumsq;
  logic [COUNT_W-1:0]         run_count;
  logic signed [SAMPLE_W-1:0] peak_hi;
  logic [MINUTE_W-1:0]        peak_hi_minute;
  logic signed [SAMPLE_W-1:0] peak_lo;
  logic [MINUTE_W-1:0]        peak_lo_minute;
  logic                       run_dropped;

  stats_t pending_stats[$];

  bit steady = 1'b0;
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_limits = 0;

  sample_min_max_mean_std_stats_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint floor_root(longint x);
    longint r;
    longint t;
    r = 0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  task automatic reset_running_stats();
    run_sum        = '0;
    run_sumsq      = '0;
    run_count      = '0;
    peak_hi        = HIGH_RESET;
    peak_hi_minute = '0;
    peak_lo        = LOW_RESET;
    peak_lo_minute = '0;
    run_dropped    = 1'b0;
  endtask

  task automatic accumulate_sample(input logic [SAMPLE_W-1:0] raw,
                                   input logic [MINUTE_W-1:0] mnt, input logic lst);
    logic signed [SAMPLE_W-1:0] s;
    logic [COUNT_W-1:0] cap;
    longint sq;
    longint n;
    longint sum;
    longint num;
    longint var_q;
    stats_t r;
    s = raw;
    if (s > SAMPLE_HI) s = SAMPLE_HI;
    if (s < SAMPLE_LO) s = SAMPLE_LO;
    cap = (limit_reg > MAX_SAMPLES) ? MAX_SAMPLES : limit_reg;
    if (run_count >= cap) begin
      run_dropped = 1'b1;
    end else begin
      sq = longint'(s) * longint'(s);
      run_sum   = run_sum + SUM_W'(longint'(s));
      run_sumsq = run_sumsq + SUMSQ_W'(sq);
      run_count = run_count + 1'b1;
      // strict compares keep the first occurrence of a tie
      if (s > peak_hi) begin
        peak_hi = s;
        peak_hi_minute = mnt;
      end
      if (s < peak_lo) begin
        peak_lo = s;
        peak_lo_minute = mnt;
      end
    end
    if (!lst) return;
    if (run_count != 0) begin
      n     = longint'(run_count);
      sum   = longint'(run_sum);
      num   = n * longint'(run_sumsq) - sum * sum;
      var_q = (num > 0) ? num / (n * n) : 0;
      r.hi_value  = peak_hi;
      r.hi_minute = peak_hi_minute;
      r.lo_value  = peak_lo;
      r.lo_minute = peak_lo_minute;
      r.mean      = SAMPLE_W'(sum / n);
      r.std_dev   = STD_W'(floor_root(var_q));
      r.count     = run_count;
      r.truncated = run_dropped;
      pending_stats.push_back(r);
    end
    reset_running_stats();
  endtask

  function automatic void cmp_field(string name, longint e, longint a);
    if (e != a) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("mismatch in result %0d, %s: expected %0d, got %0d", n_results, name, e, a);
    end
  endfunction

  task automatic check_result();
    stats_t e;
    stats_t a;
    a.hi_value  = m_tdata[14:0];
    a.hi_minute = m_tdata[25:15];
    a.lo_value  = m_tdata[40:26];
    a.lo_minute = m_tdata[51:41];
    a.mean      = m_tdata[66:52];
    a.std_dev   = m_tdata[80:67];
    a.count     = m_tdata[88:81];
    a.truncated = m_tuser[0];
    if (pending_stats.size() == 0) begin
      errors++;
      if (errors <= SHOW_LIMIT)
        $display("unexpected result: max %0d min %0d mean %0d count %0d",
                 a.hi_value, a.lo_value, a.mean, a.count);
      return;
    end
    e = pending_stats.pop_front();
    cmp_field("max_value", longint'(e.hi_value), longint'(a.hi_value));
    cmp_field("max_minute", longint'(e.hi_minute), longint'(a.hi_minute));
    cmp_field("min_value", longint'(e.lo_value), longint'(a.lo_value));
    cmp_field("min_minute", longint'(e.lo_minute), longint'(a.lo_minute));
    cmp_field("mean_value", longint'(e.mean), longint'(a.mean));
    cmp_field("std_dev", longint'(e.std_dev), longint'(a.std_dev));
    cmp_field("sample_count", longint'(e.count), longint'(a.count));
    cmp_field("truncated", longint'(e.truncated), longint'(a.truncated));
    n_results++;
  endtask

  // result side: random back-pressure, compare on every accepted result
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      m_tready <= steady || ($urandom_range(99) >= 21);
    end
  end

  task automatic send_item(input logic [SAMPLE_W-1:0] smp, input logic [MINUTE_W-1:0] mnt,
                           input logic lst);
    while (!steady && $urandom_range(99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, mnt, smp};
    s_tlast  <= lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_sample(smp, mnt, lst);
    n_items++;
  endtask

  // stop the stream, let every result drain, then let the core finish any close-out
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = v;
    n_limits++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 55) v = int'($urandom_range(19998)) - 9999;
    else if (r < 75) v = int'($urandom_range(32767));
    else if (r < 90) begin
      case ($urandom_range(5))
        0: v = 9999;
        1: v = -9999;
        2: v = 9998;
        3: v = -9998;
        4: v = 10000;
        default: v = -10000;
      endcase
    end else v = int'($urandom_range(100)) - 50;
    return v[SAMPLE_W-1:0];
  endfunction

  function automatic logic [MINUTE_W-1:0] rand_minute();
    if ($urandom_range(99) < 85) return MINUTE_W'($urandom_range(1439));
    return MINUTE_W'($urandom_range(2047));
  endfunction

  task automatic send_set(input int len);
    for (int i = 0; i < len; i++) send_item(rand_sample(), rand_minute(), i == len - 1);
  endtask

  // reset limit of 100, field extremes, saturation of out-of-range samples, ties
  task automatic test_extremes();
    send_item(15'sd9999, 11'd0, 1'b0);
    send_item(-15'sd9999, 11'd1439, 1'b0);
    send_item(15'sd9999, 11'd5, 1'b0);
    send_item(-15'sd9999, 11'd7, 1'b0);
    send_item(15'sd0, 11'd2047, 1'b1);
    send_item(15'h3FFF, 11'd100, 1'b0);
    send_item(15'h4000, 11'd200, 1'b0);
    send_item(15'sd10000, 11'd300, 1'b0);
    send_item(-15'sd10000, 11'h7FF, 1'b1);
  endtask

  // one-sample set and a negative mean that truncates toward zero
  task automatic test_mean_truncation();
    send_item(-15'sd1, 11'd1, 1'b1);
    send_item(-15'sd1, 11'd3, 1'b0);
    send_item(-15'sd2, 11'd4, 1'b1);
  endtask

  // samples past the limit are dropped, the last one included
  task automatic test_entry_limit();
    write_limit(8'd3);
    send_item(15'sd50, 11'd10, 1'b0);
    send_item(-15'sd20, 11'd11, 1'b0);
    send_item(15'sd70, 11'd12, 1'b0);
    send_item(15'sd9000, 11'd13, 1'b0);
    send_item(-15'sd9000, 11'd14, 1'b1);
  endtask

  // limit of zero: nothing accepted, a last request closes an empty set silently
  task automatic test_zero_limit();
    write_limit(8'd0);
    send_item(15'sd123, 11'd9, 1'b1);
    send_item(15'sd5, 11'd10, 1'b0);
    send_item(15'sd6, 11'd11, 1'b1);
  endtask

  task automatic test_random_sets();
    logic [7:0] limits [6];
    logic [7:0] lim;
    logic [7:0] cap;
    int budget;
    int len;
    limits = '{8'd128, 8'd1, 8'd255, 8'd7, 8'd0, 8'd100};
    for (int p = 0; p < 7; p++) begin
      lim = (p < 6) ? limits[p] : 8'($urandom_range(2, 127));
      write_limit(lim);
      steady = (p == 3);
      cap = (lim > MAX_SAMPLES) ? MAX_SAMPLES : lim;
      budget = n_items + 45;
      // one full-size set where the limit sits at the top
      if (cap == MAX_SAMPLES) send_set(int'(cap) + 1 + int'(lim != MAX_SAMPLES));
      while (n_items < budget) begin
        if ($urandom_range(99) < 12 && cap <= 16) len = int'(cap) + int'($urandom_range(3));
        else len = int'($urandom_range(1, 10));
        if (len == 0) len = 1;
        send_set(len);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    limit_reg = LIMIT_RESET;
    reset_running_stats();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_mean_truncation();
    test_entry_limit();
    test_zero_limit();
    test_random_sets();
    settle();
    $display("run covered %0d sample requests over %0d limit writes, %0d results compared",
             n_items, n_limits, n_results);
    $display("%0d mismatches, %0d results outstanding", errors, pending_stats.size());
    if (errors == 0 && pending_stats.size() == 0) begin
      $display("PASS sample_min_max_mean_std_stats_core");
    end else begin
      $display("FAIL sample_min_max_mean_std_stats_core");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_stats.size());
    $display("FAIL sample_min_max_mean_std_stats_core");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/smms_pkg.sv
rtl/smms_ctrl.sv
rtl/smms_dp.sv
rtl/sample_min_max_mean_std_stats_core.sv
tb/sv/tb.sv
